@@ rtl/core/max_heap_store_with_sort_assert.svh @@
// Assertion macros for the heap store checker.
`ifndef MAX_HEAP_STORE_WITH_SORT_ASSERT_SVH
`define MAX_HEAP_STORE_WITH_SORT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define MHS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define MHS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/core/mhs_pkg.sv @@
// Package for the heap store: action and status codes, sizes.
`default_nettype none
package mhs_pkg;
  localparam int unsigned DefDepth     = 32;
  localparam int unsigned DefWordWidth = 32;

  typedef enum logic [2:0] {
    ACT_LOAD  = 3'd0,
    ACT_PUSH  = 3'd1,
    ACT_POP   = 3'd2,
    ACT_BUILD = 3'd3,
    ACT_SORT  = 3'd4,
    ACT_CHECK = 3'd5,
    ACT_READ  = 3'd6,
    ACT_CLEAR = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;
endpackage
`default_nettype wire

@@ rtl/core/max_heap_store_with_sort.sv @@
// Binary max-heap store with build, pop, heapsort and check over one memory.
// Load, clear, small-store check and errors go straight to S_OUT; read goes via S_RD. Build
// runs one outer step per parent and a sift-down per level (read i, left, right, compare,
// write where a child moves up); push runs one pass, pop first moves the last entry to
// the root, sort adds N-1 root swaps, each sifted down. Check walks each parent. The next
// item is taken only once the result has left. Reset clears count and control, not memory.
`default_nettype none
module max_heap_store_with_sort
  import mhs_pkg::*;
#(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned WORD_WIDTH = DefWordWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: action[2:0], value[34:3], position[39:35]
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: data[31:0], heap_ok[32], occupancy[38:33], status[40:39], zero [47:41]
  output logic [47:0]      m_axis_tdata
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = CW + 1; // room for 2i+2

  typedef enum logic [3:0] {
    S_IDLE, S_BUILD, S_SD_RDI, S_SD_RDL, S_SD_RDR, S_SD_CMP, S_SD_WR,
    S_SWAP_RD0, S_SWAP_RDL, S_SWAP_WR, S_SWAP_END, S_CHK, S_POP_RD, S_POP_WR, S_RD, S_OUT
  } state_e;

  state_e                 state_q;
  logic [WORD_WIDTH-1:0]  mem [DEPTH];
  logic [WORD_WIDTH-1:0]  rdata_q;
  logic [CW-1:0]          cnt_q, len_q;
  logic [IW-1:0]          bi_q;     // build / check outer index
  logic [IW-1:0]          i_q, big_q;
  logic [WORD_WIDTH-1:0]  vi_q, vbig_q;
  logic [1:0]             chk_ph_q;
  logic                   sorting_q, in_sort_q, ok_q;
  logic [31:0]            data_q;
  logic [1:0]             status_q;

  logic [IW-1:0] li, ri;
  assign li = {i_q[IW-2:0], 1'b1};
  assign ri = {i_q[IW-2:0], 1'b0} + IW'(2);

  // Memory port, driven from the state machine.
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [WORD_WIDTH-1:0] wdata;
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  action_e act;
  assign act = action_e'(s_axis_tdata[2:0]);
  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;

  // Sign-extend or trim the 32-bit value to the stored word.
  logic [WORD_WIDTH-1:0] in_word;
  assign in_word = WORD_WIDTH'($signed(s_axis_tdata[34:3]));

  always_comb begin
    we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if ((act == ACT_LOAD || act == ACT_PUSH) && cnt_q < CW'(DEPTH)) begin
            we = 1'b1; waddr = cnt_q[AW-1:0]; wdata = in_word;
          end
          re = 1'b1;
          raddr = (act == ACT_READ) ? AW'(s_axis_tdata[39:35]) : '0;
        end
      end
      S_SD_RDI:  begin re = 1'b1; raddr = i_q[AW-1:0]; end
      S_SD_RDL:  begin re = 1'b1; raddr = li[AW-1:0]; end
      S_SD_RDR:  begin re = 1'b1; raddr = ri[AW-1:0]; end
      S_SD_WR:   begin we = 1'b1; waddr = big_q[AW-1:0]; wdata = vi_q; end
      S_SD_CMP:  begin
        if (big_q != i_q) begin we = 1'b1; waddr = i_q[AW-1:0]; wdata = vbig_q; end
      end
      S_SWAP_RD0: begin re = 1'b1; raddr = '0; end
      S_SWAP_RDL: begin re = 1'b1; raddr = AW'(len_q - CW'(1)); end
      S_SWAP_WR:  begin we = 1'b1; waddr = '0; wdata = rdata_q; end
      S_SWAP_END: begin we = 1'b1; waddr = AW'(len_q - CW'(1)); wdata = vi_q; end
      S_POP_RD:   begin re = 1'b1; raddr = AW'(cnt_q - CW'(1)); end
      S_POP_WR:   begin we = 1'b1; waddr = '0; wdata = rdata_q; end
      S_CHK: begin
        re = 1'b1;
        case (chk_ph_q)
          2'd0: raddr = bi_q[AW-1:0];
          2'd1: raddr = AW'({bi_q[IW-2:0], 1'b1});
          default: raddr = AW'({bi_q[IW-2:0], 1'b0} + IW'(2));
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; m_axis_tvalid <= 1'b0;
      len_q <= '0; bi_q <= '0; i_q <= '0; big_q <= '0; chk_ph_q <= '0;
      sorting_q <= 1'b0; in_sort_q <= 1'b0; ok_q <= 1'b0;
      data_q <= '0; status_q <= ST_OK; vi_q <= '0; vbig_q <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            data_q <= '0; ok_q <= 1'b0; status_q <= ST_OK;
            sorting_q <= 1'b0; in_sort_q <= 1'b0;
            bi_q <= IW'(cnt_q >> 1); len_q <= cnt_q;
            state_q <= S_OUT;
            case (act)
              ACT_LOAD, ACT_PUSH: begin
                if (cnt_q >= CW'(DEPTH)) status_q <= ST_FULL;
                else begin
                  cnt_q <= cnt_q + CW'(1);
                  len_q <= cnt_q + CW'(1);
                  bi_q <= IW'((cnt_q + CW'(1)) >> 1);
                  if (act == ACT_PUSH) state_q <= S_BUILD;
                end
              end
              ACT_POP: begin
                if (cnt_q == '0) status_q <= ST_EMPTY;
                else state_q <= S_POP_RD;
              end
              ACT_BUILD: state_q <= S_BUILD;
              ACT_SORT: begin sorting_q <= 1'b1; state_q <= S_BUILD; end
              ACT_CHECK: begin
                ok_q <= 1'b1; bi_q <= '0; chk_ph_q <= '0;
                state_q <= (cnt_q < CW'(2)) ? S_OUT : S_CHK;
              end
              ACT_READ: begin
                if (CW'(s_axis_tdata[39:35]) >= cnt_q ||
                    32'(s_axis_tdata[39:35]) >= DEPTH) status_q <= ST_RANGE;
                else state_q <= S_RD;
              end
              default: cnt_q <= '0;
            endcase
          end
        end
        S_RD: begin
          data_q <= 32'($signed(rdata_q)); state_q <= S_OUT;
        end
        S_POP_RD: begin
          // rdata_q holds the front entry here
          data_q <= 32'($signed(rdata_q)); state_q <= S_POP_WR;
        end
        S_POP_WR: begin
          cnt_q <= cnt_q - CW'(1);
          len_q <= cnt_q - CW'(1);
          bi_q <= IW'((cnt_q - CW'(1)) >> 1);
          state_q <= S_BUILD;
        end
        S_BUILD: begin
          // Advance the bottom-up pass, then the sort loop if asked.
          if (in_sort_q) begin
            if (len_q > CW'(1)) state_q <= S_SWAP_RD0;
            else begin in_sort_q <= 1'b0; state_q <= S_OUT; end
          end else if (bi_q != '0) begin
            i_q <= bi_q - IW'(1); bi_q <= bi_q - IW'(1); state_q <= S_SD_RDI;
          end else if (sorting_q && cnt_q > CW'(1)) begin
            sorting_q <= 1'b0; in_sort_q <= 1'b1; len_q <= cnt_q;
            state_q <= S_SWAP_RD0;
          end else state_q <= S_OUT;
        end
        S_SWAP_RD0: state_q <= S_SWAP_RDL;
        S_SWAP_RDL: begin vi_q <= rdata_q; state_q <= S_SWAP_WR; end
        S_SWAP_WR: state_q <= S_SWAP_END;
        S_SWAP_END: begin
          // old root now sits at the end; shrink and sift from the root
          i_q <= '0;
          len_q <= len_q - CW'(1);
          state_q <= S_SD_RDI;
        end
        S_SD_RDI: state_q <= S_SD_RDL;
        S_SD_RDL: begin vi_q <= rdata_q; vbig_q <= rdata_q; big_q <= i_q;
          state_q <= S_SD_RDR; end
        S_SD_RDR: begin
          if (li < IW'(len_q) && $signed(rdata_q) > $signed(vbig_q)) begin
            vbig_q <= rdata_q; big_q <= li;
          end
          state_q <= S_SD_CMP;
        end
        S_SD_CMP: begin
          if (ri < IW'(len_q) && $signed(rdata_q) > $signed(vbig_q)) begin
            vbig_q <= rdata_q; big_q <= ri; state_q <= S_SD_CMP;
            // re-evaluate write with new choice next cycle
          end else if (big_q == i_q) begin
            state_q <= S_BUILD;
          end else begin
            state_q <= S_SD_WR;
          end
        end
        S_SD_WR: begin
          // drop the parent into the child slot, continue below
          i_q <= big_q;
          state_q <= S_SD_RDI;
        end
        S_CHK: begin
          case (chk_ph_q)
            2'd0: chk_ph_q <= 2'd1;
            2'd1: begin vi_q <= rdata_q; chk_ph_q <= 2'd2; end
            2'd2: begin vbig_q <= rdata_q; chk_ph_q <= 2'd3; end
            default: begin
              if ($signed(vbig_q) > $signed(vi_q)) ok_q <= 1'b0;
              if ({bi_q[IW-2:0], 1'b0} + IW'(2) < IW'(cnt_q) &&
                  $signed(rdata_q) > $signed(vi_q)) ok_q <= 1'b0;
              chk_ph_q <= 2'd0;
              bi_q <= bi_q + IW'(1);
              if (bi_q + IW'(1) >= IW'(cnt_q >> 1)) state_q <= S_OUT;
            end
          endcase
        end
        S_OUT: begin m_axis_tvalid <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, status_q, 6'(cnt_q), ok_q, data_q};
endmodule
`default_nettype wire

@@ rtl/core/mhs_checker.sv @@
// Port-level checker for the heap store, bound to the top level.
`default_nettype none
`include "max_heap_store_with_sort_assert.svh"
module mhs_checker
  import mhs_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [39:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  `MHS_ASSERT_IMP(a_occ_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[38:33] <= 6'd32)
  `MHS_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[47:41] == 7'd0)
  `MHS_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `MHS_ASSERT_IMP(a_err_nodata, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[40:39] != 2'd0,
                  m_axis_tdata[31:0] == 32'd0)
endmodule
bind max_heap_store_with_sort mhs_checker u_mhs_checker (.*);
`default_nettype wire
